// ===== sv/dfp_pkg.sv =====
// ---------------------------------------------------------------------------
// dfp_pkg: shared types and constants of the decimal field frame parser
// Character codes, field limit, parse phase encoding and result beat layout.
// ---------------------------------------------------------------------------
package dfp_pkg;

   localparam int MAX_FIELDS   = 16;
   localparam int FIELD_LIMIT  = (MAX_FIELDS > 16) ? 16 : MAX_FIELDS;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEP   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] START_RESET = 8'h23;

   localparam logic [4:0] FIELD_LIMIT_W = 5'(FIELD_LIMIT);

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_BODY = 3'b010,
      PHASE_CR   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [31:0] field_value;
      logic [3:0]  field_number;
      logic        last_field;
      logic        frame_error;
      logic        field_overflow;
   } result_type;

endpackage

// ===== sv/dfp_parse.sv =====
// ---------------------------------------------------------------------------
// dfp_parse: frame state and per-byte parse step
// Holds phase, accumulator, field count and overflow flag; folds one byte per
// enabled cycle and reports whether that byte produces a result beat.
// ---------------------------------------------------------------------------
module dfp_parse
   import dfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  start_char,
   output logic        has_result,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;
   logic        ovf_ff, ovf_in;

   logic [31:0] acc_fold;
   logic [4:0]  count_next;
   logic        count_room;

   assign acc_fold   = (acc_ff << 3) + (acc_ff << 1) + {24'd0, rx_byte} - {24'd0, CHAR_ZERO};
   assign count_next = {1'b0, count_ff} + 5'd1;
   assign count_room = count_next < FIELD_LIMIT_W;

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      has_result = 1'b0;
      result     = '{field_value: acc_ff, field_number: count_ff, last_field: 1'b0,
                     frame_error: 1'b0, field_overflow: ovf_ff};
      unique case (phase_ff)
         PHASE_BODY: begin
            if (rx_byte == CHAR_CR) begin
               phase_in = PHASE_CR;
            end else if (rx_byte == CHAR_SEP || rx_byte == CHAR_NUL) begin
               has_result = 1'b1;
               acc_in     = '0;
               if (count_room) begin
                  count_in = count_next[3:0];
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               acc_in = acc_fold;
            end
         end
         PHASE_CR: begin
            has_result = 1'b1;
            if (rx_byte == CHAR_LF) begin
               result.last_field = 1'b1;
            end else begin
               result = '{field_value: '0, field_number: '0, last_field: 1'b1,
                          frame_error: 1'b1, field_overflow: ovf_ff};
            end
            phase_in = PHASE_IDLE;
            acc_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end
         default: begin
            phase_in = PHASE_IDLE;
            if (rx_byte == start_char) begin
               phase_in = PHASE_BODY;
               acc_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         acc_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== sv/decimal_field_frame_parser_top.sv =====
// ---------------------------------------------------------------------------
// decimal_field_frame_parser_top: framed decimal field parser
// Cuts colon separated decimal fields out of a byte stream framed by a start
// character and CR LF.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  req      | req_valid / req_ready  | req_rx_byte
//  rsp      | rsp_valid / rsp_ready  | rsp_field_value, _number, last, error, overflow
//  csr      | csr_wr_en              | csr_wr_data (start character)
//
//  One byte per cycle, except that a byte with a result stalls while a result beat waits.
//  Input register feeds one parse step into the result register.
//  A byte without a result passes even while a result beat waits.
//  Synchronous reset clears frame state and sets start character to '#'.
// ---------------------------------------------------------------------------
module decimal_field_frame_parser_top
   import dfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_field_value,
   output logic [3:0]  rsp_field_number,
   output logic        rsp_last_field,
   output logic        rsp_frame_error,
   output logic        rsp_field_overflow,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0] start_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;

   logic       has_result;
   result_type result;
   logic       advance;
   logic       out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   dfp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .start_char (start_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
      end else if (csr_wr_en) begin
         start_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_field_value    = out_ff.field_value;
   assign rsp_field_number   = out_ff.field_number;
   assign rsp_last_field     = out_ff.last_field;
   assign rsp_frame_error    = out_ff.frame_error;
   assign rsp_field_overflow = out_ff.field_overflow;

endmodule
